[sv/csrmv_pkg.sv]
// ----------------------------------------------------------------------------
// csrmv_pkg: shared types and constants for the sparse matrix-vector block
// Field widths, default parameter values, item kinds and the structs that
// pass pipeline items between stages.
// ----------------------------------------------------------------------------
package csrmv_pkg;

  localparam int DEF_VECTOR_DEPTH = 1024;
  localparam int DEF_FRAC_BITS    = 16;

  localparam int KIND_W   = 2;
  localparam int COLUMN_W = 10;
  localparam int DATA_W   = 32;
  localparam int ACC_W    = 64;
  localparam int ROW_W    = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 2'd0,
    KIND_NONZERO = 2'd1,
    KIND_EMPTY   = 2'd2
  } kind_t;

  // Nonzero or empty-row item after the vector element lookup
  typedef struct packed {
    logic                     valid;
    logic                     empty;
    logic                     last;
    logic signed [DATA_W-1:0] operand;
    logic signed [DATA_W-1:0] element;
  } fetch_t;

  // Finished row waiting for rounding and clamping
  typedef struct packed {
    logic                    valid;
    logic                    empty;
    logic [ROW_W-1:0]        row_number;
    logic signed [ACC_W-1:0] acc;
    logic                    flag;
  } fin_t;

endpackage

[sv/csrmv_cmd_if.sv]
// ----------------------------------------------------------------------------
// csrmv_cmd_if: input item channel
// Valid/ready channel carrying load, nonzero and empty-row items.
// ----------------------------------------------------------------------------
interface csrmv_cmd_if
  import csrmv_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [COLUMN_W-1:0]      column;
  logic signed [DATA_W-1:0] operand;
  logic                     row_last;

  modport source (output valid, kind, column, operand, row_last, input ready);
  modport sink   (input valid, kind, column, operand, row_last, output ready);
endinterface

[sv/csrmv_res_if.sv]
// ----------------------------------------------------------------------------
// csrmv_res_if: result item channel
// Valid/ready channel carrying one finished row sum per item.
// ----------------------------------------------------------------------------
interface csrmv_res_if
  import csrmv_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [ROW_W-1:0]         row_number;
  logic signed [DATA_W-1:0] row_sum;
  logic                     saturated;

  modport source (output valid, row_number, row_sum, saturated, input ready);
  modport sink   (input valid, row_number, row_sum, saturated, output ready);
endinterface

[sv/csr_sparse_matvec.sv]
// ----------------------------------------------------------------------------
// csr_sparse_matvec: sparse matrix times dense vector, row-compressed order
// Top level: vector store lookup, multiply-accumulate and row rounding.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries input items: loads write a Q16.16 vector element, nonzeros
//   multiply their value by the stored element at their column and add it to
//   the row accumulator, and empty-row items give a zero row. A nonzero with
//   row_last set, or an empty-row item, yields one item on res: the row
//   number, the Q16.16 sum rounded half up and clamped, and a saturation flag.
//   Load a vector element before any nonzero reads its column.
// Timing:
//   One item per cycle sustained while res keeps taking results. The item that
//   ends a row passes the store read register, the product register and the
//   accumulate register; its result then leaves through the output register.
//   The row accumulator loop is a single 64-bit saturating add per cycle.
// Reset:
//   Clears the accumulator, overflow flag, row counter and all stage valids.
//   The vector store is not cleared.
// Stall:
//   When res is held, the result waits in the output register and the three
//   earlier stages keep filling; cmd drops ready once they are all full.
// ----------------------------------------------------------------------------
module csr_sparse_matvec
  import csrmv_pkg::*;
#(
  parameter int VECTOR_DEPTH = DEF_VECTOR_DEPTH,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  csrmv_cmd_if.sink   cmd,
  csrmv_res_if.source res
);

  fetch_t fetch;
  fin_t   fin;
  logic   mac_ready;
  logic   fin_ready;

  csrmv_fetch #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_fetch (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .next_ready (mac_ready),
    .fetch      (fetch)
  );

  csrmv_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .fetch     (fetch),
    .ready     (mac_ready),
    .fin_ready (fin_ready),
    .fin       (fin)
  );

  csrmv_round #(
    .FRAC_BITS (FRAC_BITS)
  ) u_round (
    .clk       (clk),
    .rst       (rst),
    .fin       (fin),
    .fin_ready (fin_ready),
    .res       (res)
  );

endmodule

[sv/csrmv_fetch.sv]
// ----------------------------------------------------------------------------
// csrmv_fetch: vector store and input register
// Writes load items into the vector store and looks up the element for
// each nonzero; registers the item for the multiply stage.
// ----------------------------------------------------------------------------
module csrmv_fetch
  import csrmv_pkg::*;
#(
  parameter int VECTOR_DEPTH = DEF_VECTOR_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  csrmv_cmd_if.sink   cmd,
  input  logic        next_ready,
  output fetch_t      fetch
);

  localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam int XW = AW + COLUMN_W;

  logic [DATA_W-1:0] mem [VECTOR_DEPTH];

  logic [XW-1:0]     col_ext;
  logic [AW-1:0]     addr;
  logic              in_range;
  logic              accept;
  kind_t             kind;

  logic              valid;
  logic              empty;
  logic              last;
  logic              hit;
  logic [DATA_W-1:0] operand;
  logic [DATA_W-1:0] rdata;

  assign col_ext  = {{AW{1'b0}}, cmd.column};
  assign addr     = col_ext[AW-1:0];
  assign in_range = col_ext < XW'(VECTOR_DEPTH);
  assign kind     = kind_t'(cmd.kind);

  assign cmd.ready = !valid || next_ready;
  assign accept    = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (accept && kind == KIND_LOAD && in_range) begin
      mem[addr] <= cmd.operand;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready) begin
      rdata   <= mem[addr];
      hit     <= in_range;
      empty   <= (kind == KIND_EMPTY);
      last    <= cmd.row_last;
      operand <= cmd.operand;
    end
  end

  // Only nonzero and empty-row items travel on; loads and kind three end here
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ready) begin
      if (accept) begin
        unique case (kind)
          KIND_NONZERO, KIND_EMPTY: valid <= 1'b1;
          default:                  valid <= 1'b0;
        endcase
      end else begin
        valid <= 1'b0;
      end
    end
  end

  always_comb begin
    fetch.valid   = valid;
    fetch.empty   = empty;
    fetch.last    = last;
    fetch.operand = operand;
    fetch.element = hit ? rdata : '0;
  end

endmodule

[sv/csrmv_mac.sv]
// ----------------------------------------------------------------------------
// csrmv_mac: multiply and row accumulate
// Registers the full 64-bit product, then adds it to the row accumulator
// with saturation and hands finished rows to the rounding stage.
// ----------------------------------------------------------------------------
module csrmv_mac
  import csrmv_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  fetch_t fetch,
  output logic   ready,
  input  logic   fin_ready,
  output fin_t   fin
);

  logic                    p_valid;
  logic                    p_empty;
  logic                    p_last;
  logic signed [ACC_W-1:0] prod;

  logic signed [ACC_W-1:0] acc;
  logic                    flag;
  logic [ROW_W-1:0]        row_counter;

  logic                    fin_valid;
  logic                    fin_empty;
  logic [ROW_W-1:0]        fin_row;
  logic signed [ACC_W-1:0] fin_acc;
  logic                    fin_flag;

  logic                    advance;
  logic signed [ACC_W-1:0] sum;
  logic                    ovf;
  logic signed [ACC_W-1:0] sat_sum;

  assign advance = p_valid && (!fin_valid || fin_ready);
  assign ready   = !p_valid || advance;

  always_ff @(posedge clk) begin
    if (ready) begin
      p_empty <= fetch.empty;
      p_last  <= fetch.last;
      prod    <= fetch.operand * fetch.element;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (ready) begin
      p_valid <= fetch.valid;
    end
  end

  always_comb begin
    sum     = acc + prod;
    ovf     = (acc[ACC_W-1] == prod[ACC_W-1]) && (sum[ACC_W-1] != acc[ACC_W-1]);
    sat_sum = sum;
    if (ovf) begin
      sat_sum = acc[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fin_empty <= p_empty;
      fin_row   <= row_counter;
      fin_acc   <= sat_sum;
      fin_flag  <= flag || ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid   <= 1'b0;
      acc         <= '0;
      flag        <= 1'b0;
      row_counter <= '0;
    end else if (advance) begin
      fin_valid <= p_empty || p_last;
      if (p_empty) begin
        // leave a partial row alone
        row_counter <= row_counter + 1'b1;
      end else if (p_last) begin
        acc         <= '0;
        flag        <= 1'b0;
        row_counter <= row_counter + 1'b1;
      end else begin
        acc  <= sat_sum;
        flag <= flag || ovf;
      end
    end else if (fin_ready) begin
      fin_valid <= 1'b0;
    end
  end

  always_comb begin
    fin.valid      = fin_valid;
    fin.empty      = fin_empty;
    fin.row_number = fin_row;
    fin.acc        = fin_acc;
    fin.flag       = fin_flag;
  end

endmodule

[sv/csrmv_round.sv]
// ----------------------------------------------------------------------------
// csrmv_round: row sum rounding and output register
// Shifts the accumulator down to Q16.16, rounds half up, clamps to the
// 32-bit range and holds the result item until it is taken.
// ----------------------------------------------------------------------------
module csrmv_round
  import csrmv_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  fin_t         fin,
  output logic         fin_ready,
  csrmv_res_if.source  res
);

  localparam logic signed [ACC_W:0] Q_MAX = (ACC_W+1)'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W:0] Q_MIN = -((ACC_W+1)'(64'sh8000_0000));

  logic signed [ACC_W:0] acc_ext;
  logic signed [ACC_W:0] shifted;
  logic signed [ACC_W:0] q;
  logic                  round_bit;
  logic signed [DATA_W-1:0] sum_next;
  logic                  sat_next;

  if (FRAC_BITS > 0) begin : g_round
    assign round_bit = fin.acc[FRAC_BITS-1];
  end else begin : g_exact
    assign round_bit = 1'b0;
  end

  assign acc_ext = {fin.acc[ACC_W-1], fin.acc};
  assign shifted = acc_ext >>> FRAC_BITS;
  assign q       = shifted + {{ACC_W{1'b0}}, round_bit};

  always_comb begin
    sum_next = q[DATA_W-1:0];
    sat_next = fin.flag;
    if (fin.empty) begin
      sum_next = '0;
      sat_next = 1'b0;
    end else if (q > Q_MAX) begin
      sum_next = {1'b0, {(DATA_W-1){1'b1}}};
      sat_next = 1'b1;
    end else if (q < Q_MIN) begin
      sum_next = {1'b1, {(DATA_W-1){1'b0}}};
      sat_next = 1'b1;
    end
  end

  assign fin_ready = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (fin_ready) begin
      res.row_number <= fin.row_number;
      res.row_sum    <= sum_next;
      res.saturated  <= sat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (fin_ready) begin
      res.valid <= fin.valid;
    end
  end

endmodule

[verif/csr_sparse_matvec_tb.sv]
// ----------------------------------------------------------------------------
// csr_sparse_matvec_tb: self-checking bench for the sparse matrix-vector block
// Drives load, nonzero, empty-row and unused-kind items with random gaps
// on both channels. Includes one long output hold-off. Every finished row
// is compared field by field against a bit-exact Q16.16 row sum predictor or typed row.
// A short directed table comes first, then constrained-by-hand random rows.
// ----------------------------------------------------------------------------
module csr_sparse_matvec_tb;
  import csrmv_pkg::*;

  localparam int STORE_DEPTH    = DEF_VECTOR_DEPTH;
  localparam int FRAC           = DEF_FRAC_BITS;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int HOLD_CYCLES    = 300;
  localparam int IDLE_LIMIT     = 3000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PRESSURE_POINT = 400;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SUM_MAX = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] SUM_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [COLUMN_W-1:0]      column;
    logic signed [DATA_W-1:0] operand;
    logic                     row_last;
  } cmd_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]         row_number;
    logic signed [DATA_W-1:0] row_sum;
    logic                     saturated;
  } row_result_t;

  typedef struct packed {
    cmd_item_t   item;
    logic        typed;
    row_result_t typed_row;
  } table_step_t;

  logic clk;
  logic rst;

  csrmv_cmd_if cmd();
  csrmv_res_if res();

  csr_sparse_matvec dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .res(res)
  );

  // Predictor state
  logic signed [DATA_W-1:0] vec_mirror [STORE_DEPTH];
  logic signed [ACC_W-1:0]  acc_mirror;
  logic [ROW_W-1:0]         row_mirror;
  logic                     ovf_mirror;

  bit                 loaded [STORE_DEPTH];
  int                 loaded_cols [$];
  row_result_t        expected_rows [$];
  table_step_t        directed [$];

  int  error_count;
  int  counted_items;
  int  n_loads, n_nonzeros, n_empties, n_ignored, n_rows_checked, n_sat_rows;
  int  idle_cycles;
  bit  hold_request;
  bit  hold_active;
  bit  send_calm;
  bit  recv_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bit-exact row step: returns 1 when the item finishes a row
  function automatic bit matvec_step(input cmd_item_t it, output row_result_t row);
    logic signed [ACC_W-1:0] op64;
    logic signed [ACC_W-1:0] el64;
    logic signed [ACC_W-1:0] product;
    logic signed [ACC_W-1:0] total;
    logic signed [ACC_W-1:0] q;
    logic                    flag;
    row = '0;
    case (it.kind)
      KIND_LOAD: begin
        vec_mirror[it.column] = it.operand;
        return 1'b0;
      end
      KIND_NONZERO: begin
        op64 = $signed(it.operand);
        el64 = $signed(vec_mirror[it.column]);
        product = op64 * el64;
        total = acc_mirror + product;
        if (acc_mirror[ACC_W-1] == product[ACC_W-1] &&
            total[ACC_W-1] != acc_mirror[ACC_W-1]) begin
          ovf_mirror = 1'b1;
          total = acc_mirror[ACC_W-1] ? ACC_MIN : ACC_MAX;
        end
        acc_mirror = total;
        if (!it.row_last) return 1'b0;
        // round half up, then clamp to Q16.16
        q = acc_mirror >>> FRAC;
        if (acc_mirror[FRAC-1]) q = q + 1;
        flag = ovf_mirror;
        if (q > SUM_MAX) begin
          q = SUM_MAX;
          flag = 1'b1;
        end else if (q < SUM_MIN) begin
          q = SUM_MIN;
          flag = 1'b1;
        end
        row.row_number = row_mirror;
        row.row_sum    = q[DATA_W-1:0];
        row.saturated  = flag;
        row_mirror = row_mirror + 1'b1;
        acc_mirror = '0;
        ovf_mirror = 1'b0;
        return 1'b1;
      end
      KIND_EMPTY: begin
        row.row_number = row_mirror;
        row_mirror = row_mirror + 1'b1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] draw_operand();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 4))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'hFFFF_FFFF;
        3: return 32'h0000_0001;
        default: return '0;
      endcase
    end
    if (sel < 3) return $urandom();
    // mostly within +/-16.0 so sums stay in range
    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
  endfunction

  task automatic add_step(input logic [KIND_W-1:0] kind, input int column,
                          input logic [DATA_W-1:0] operand, input bit last,
                          input bit typed = 1'b0, input int row_number = 0,
                          input logic [DATA_W-1:0] row_sum = '0,
                          input bit saturated = 1'b0);
    table_step_t s;
    s.item.kind           = kind;
    s.item.column         = COLUMN_W'(column);
    s.item.operand        = operand;
    s.item.row_last       = last;
    s.typed               = typed;
    s.typed_row.row_number = ROW_W'(row_number);
    s.typed_row.row_sum   = row_sum;
    s.typed_row.saturated = saturated;
    directed.push_back(s);
  endtask

  // Offer one item; returns at the edge where it was accepted
  task automatic send_item(input cmd_item_t it, input bit typed = 1'b0,
                           input row_result_t typed_row = '0);
    int          wait_n;
    bit          took;
    row_result_t row;
    if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
    wait_n = (send_calm || hold_active) ? 0 : $urandom_range(0, 16);
    if (wait_n > 0) begin
      cmd.valid <= 1'b0;
      repeat (wait_n) @(posedge clk);
    end
    cmd.valid    <= 1'b1;
    cmd.kind     <= it.kind;
    cmd.column   <= it.column;
    cmd.operand  <= it.operand;
    cmd.row_last <= it.row_last;
    do begin
      @(negedge clk);
      took = cmd.ready;
      @(posedge clk);
    end while (!took);

    case (it.kind)
      KIND_LOAD: begin
        n_loads++;
        if (!loaded[it.column]) begin
          loaded[it.column] = 1'b1;
          loaded_cols.push_back(int'(it.column));
        end
      end
      KIND_NONZERO: n_nonzeros++;
      KIND_EMPTY:   n_empties++;
      default:      n_ignored++;
    endcase
    if (it.kind != KIND_UNUSED) counted_items++;

    if (matvec_step(it, row)) begin
      if (typed) row = typed_row;
      if (row.saturated) n_sat_rows++;
      expected_rows.push_back(row);
    end
  endtask

  task automatic send_random(input logic [KIND_W-1:0] kind, input bit last);
    cmd_item_t it;
    it.kind     = kind;
    it.operand  = draw_operand();
    it.row_last = last;
    if (kind == KIND_NONZERO)
      it.column = COLUMN_W'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
    else
      it.column = COLUMN_W'($urandom_range(0, STORE_DEPTH - 1));
    send_item(it);
  endtask

  task automatic check_row(input row_result_t got);
    row_result_t want;
    n_rows_checked++;
    if (expected_rows.size() == 0) begin
      $display("%0t: unexpected row: row_number %0d row_sum %h saturated %b",
               $time, got.row_number, got.row_sum, got.saturated);
      error_count++;
      return;
    end
    want = expected_rows.pop_front();
    if (got.row_number !== want.row_number) begin
      $display("%0t: row_number expected %0d actual %0d",
               $time, want.row_number, got.row_number);
      error_count++;
    end
    if (got.row_sum !== want.row_sum) begin
      $display("%0t: row %0d row_sum expected %h actual %h",
               $time, want.row_number, want.row_sum, got.row_sum);
      error_count++;
    end
    if (got.saturated !== want.saturated) begin
      $display("%0t: row %0d saturated expected %b actual %b",
               $time, want.row_number, want.saturated, got.saturated);
      error_count++;
    end
  endtask

  // Result side: random back-pressure plus one long hold-off
  initial begin
    int          wait_n;
    bit          took;
    row_result_t got;
    res.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
      end else begin
        wait_n = recv_calm ? 0 : $urandom_range(0, 16);
        if (wait_n > 0) begin
          res.ready <= 1'b0;
          repeat (wait_n) @(posedge clk);
        end
      end
      res.ready <= 1'b1;
      do begin
        @(negedge clk);
        took = res.valid;
        got.row_number = res.row_number;
        got.row_sum    = res.row_sum;
        got.saturated  = res.saturated;
        @(posedge clk);
      end while (!took);
      check_row(got);
    end
  end

  // Watchdog: cycles with no item accepted on either channel
  always @(negedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles, %0d rows outstanding",
               $time, IDLE_LIMIT, expected_rows.size());
      $display("csr_sparse_matvec_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          pick;
    int          len;
    bit          pressure_done;
    table_step_t s;
    rst          = 1'b1;
    cmd.valid    = 1'b0;
    cmd.kind     = KIND_LOAD;
    cmd.column   = '0;
    cmd.operand  = '0;
    cmd.row_last = 1'b0;
    acc_mirror   = '0;
    row_mirror   = '0;
    ovf_mirror   = 1'b0;
    foreach (vec_mirror[i]) vec_mirror[i] = '0;
    pressure_done = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, saturation both ways, rounding ties, split rows
    add_step(KIND_EMPTY,   0,    32'h0000_0000, 0, 1, 0, 32'h0000_0000, 0);
    add_step(KIND_LOAD,    0,    32'h7FFF_FFFF, 1);
    add_step(KIND_LOAD,    1023, 32'h8000_0000, 0);
    add_step(KIND_NONZERO, 0,    32'h7FFF_FFFF, 1, 1, 1, 32'h7FFF_FFFF, 1);
    add_step(KIND_NONZERO, 1023, 32'h8000_0000, 1, 1, 2, 32'h7FFF_FFFF, 1);
    add_step(KIND_NONZERO, 0,    32'h8000_0000, 1, 1, 3, 32'h8000_0000, 1);
    add_step(KIND_NONZERO, 1023, 32'h8000_0000, 0);
    add_step(KIND_NONZERO, 1023, 32'h8000_0000, 0);
    add_step(KIND_NONZERO, 0,    32'h8000_0000, 1, 1, 4, 32'h7FFF_FFFF, 1);
    add_step(KIND_LOAD,    1,    32'h7FFF_FFFF, 0);
    add_step(KIND_NONZERO, 1,    32'h8000_0000, 0);
    add_step(KIND_NONZERO, 1,    32'h8000_0000, 0);
    add_step(KIND_NONZERO, 1,    32'h8000_0000, 1, 1, 5, 32'h8000_0000, 1);
    add_step(KIND_LOAD,    5,    32'h0001_0000, 0);
    add_step(KIND_NONZERO, 5,    32'h0002_0000, 1);
    add_step(KIND_LOAD,    6,    32'h0000_0001, 0);
    add_step(KIND_NONZERO, 6,    32'h0000_8000, 1);
    add_step(KIND_NONZERO, 6,    32'hFFFF_8000, 1);
    add_step(KIND_NONZERO, 5,    32'h0003_0000, 0);
    add_step(KIND_EMPTY,   0,    32'h0000_0000, 0, 1, 9, 32'h0000_0000, 0);
    add_step(KIND_NONZERO, 5,    32'hFFFF_0000, 1);
    add_step(KIND_UNUSED,  1023, 32'hFFFF_FFFF, 1);
    add_step(KIND_LOAD,    1023, 32'hFFFF_FFFF, 0);
    add_step(KIND_NONZERO, 1023, 32'h8000_0000, 1);
    add_step(KIND_NONZERO, 6,    32'h0000_0000, 1);
    foreach (directed[i]) begin
      s = directed[i];
      send_item(s.item, s.typed, s.typed_row);
    end

    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      if (!pressure_done && counted_items >= PRESSURE_POINT) begin
        hold_request  = 1'b1;
        pressure_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_random(KIND_LOAD, 1'b0);
      end else if (pick < 75) begin
        // well-formed row, now and then split by an empty row
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          send_random(KIND_NONZERO, k == len - 1);
          if (k < len - 1 && $urandom_range(0, 9) == 0)
            send_random(KIND_EMPTY, 1'($urandom_range(0, 1)));
        end
      end else if (pick < 85) begin
        send_random(KIND_EMPTY, 1'($urandom_range(0, 1)));
      end else if (pick < 92) begin
        // row left open: it merges into the next row that a nonzero ends
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) send_random(KIND_NONZERO, 1'b0);
      end else if (pick < 96) begin
        send_random(KIND_LOAD, 1'b1);
      end else begin
        send_random(KIND_UNUSED, 1'($urandom_range(0, 1)));
      end
    end
    cmd.valid <= 1'b0;

    while (expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d loads, %0d nonzeros, %0d empty rows, %0d unused-kind items.",
             n_loads, n_nonzeros, n_empties, n_ignored);
    $display("Checked %0d rows, %0d of them flagged saturated; %0d mismatches.",
             n_rows_checked, n_sat_rows, error_count);
    if (error_count == 0) begin
      $display("csr_sparse_matvec_tb: clean");
    end else begin
      $display("csr_sparse_matvec_tb: errors");
    end
    $finish;
  end

endmodule
